@@ design/ssmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Single-switch mode controller package
// Shared constants, register indexes and mode helper functions.
// ----------------------------------------------------------------------------
package ssmc_pkg;

   localparam int unsigned MODE_COUNT      = 7;
   localparam int unsigned MODE_WIDTH      = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam logic [7:0]  FULL_LEVEL      = 8'd255;

   localparam logic [7:0] LEVEL_TABLE [8] = '{
      8'd0, 8'd1, 8'd3, 8'd12, 8'd40, 8'd125, 8'd255, 8'd255
   };

   localparam logic        REVERSE_ORDER_RESET      = 1'b0;
   localparam logic [6:0]  LONG_PRESS_TICKS_RESET   = 7'd33;
   localparam logic [15:0] TURBO_LIMIT_RESET        = 16'd5625;
   localparam logic [7:0]  LOW_THRESHOLD_RESET      = 8'd130;
   localparam logic [7:0]  CRITICAL_THRESHOLD_RESET = 8'd120;
   localparam logic [7:0]  RECHECK_DELAY_RESET      = 8'd188;
   localparam logic [5:0]  READOUT_STEP_RESET       = 6'd11;
   localparam logic [7:0]  RELEASE_MASK_RESET       = 8'h0F;
   localparam logic [2:0]  STRIKE_LIMIT             = 3'd4;

   typedef enum logic [2:0] {
      CSR_REVERSE_ORDER,
      CSR_LONG_PRESS_TICKS,
      CSR_TURBO_LIMIT,
      CSR_LOW_THRESHOLD,
      CSR_CRITICAL_THRESHOLD,
      CSR_RECHECK_DELAY,
      CSR_READOUT_STEP,
      CSR_RELEASE_MASK
   } csr_index_type;

   function automatic logic [7:0] level_of(input logic [MODE_WIDTH-1:0] mode);
      level_of = LEVEL_TABLE[mode];
   endfunction

   function automatic logic [MODE_WIDTH-1:0] mode_up(input logic [MODE_WIDTH-1:0] mode);
      logic [MODE_WIDTH:0] next;
      next = {1'b0, mode} + (MODE_WIDTH+1)'(1);
      mode_up = (next >= (MODE_WIDTH+1)'(MODE_COUNT)) ? '0 : next[MODE_WIDTH-1:0];
   endfunction

   function automatic logic [MODE_WIDTH-1:0] mode_down(input logic [MODE_WIDTH-1:0] mode);
      mode_down = (mode == '0) ? MODE_WIDTH'(MODE_COUNT - 1)
                               : mode - MODE_WIDTH'(1);
   endfunction

endpackage
`default_nettype wire

@@ design/single_switch_mode_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Single-switch mode controller
// Debounces one switch, steps through the light modes, steps down on turbo
// timeout and low battery, and reports a battery readout after a tap to off.
// ----------------------------------------------------------------------------
// One request word is one tick. The finish state loads its response word;
// the divide state comes first when a division is needed: a held press needs
// the press count modulo the long-press length, and an armed readout needs
// the blink count quotient. Both go through one shared 8-step restoring
// divider, one quotient bit per cycle. The next word is accepted in the cycle
// after the response is loaded, so the response may wait under stall while
// the next word is taken; a further word waits until that response leaves.
module single_switch_mode_controller (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire logic                         req_switch_down,
   input  wire logic                         req_sample_ready,
   input  wire logic [7:0]                   req_battery_sample,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic [2:0]                   rsp_mode_number,
   output      logic [7:0]                   rsp_drive_level,
   output      logic                         rsp_start_sample,
   output      logic [7:0]                   rsp_blink_count,
   input  wire logic                         csr_write_enable,
   input  wire ssmc_pkg::csr_index_type      csr_index,
   input  wire logic [ssmc_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);
   import ssmc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic        reverse_order_ff, reverse_order_in;
   logic [6:0]  long_press_ticks_ff, long_press_ticks_in;
   logic [15:0] turbo_limit_ff, turbo_limit_in;
   logic [7:0]  low_threshold_ff, low_threshold_in;
   logic [7:0]  critical_threshold_ff, critical_threshold_in;
   logic [7:0]  recheck_delay_ff, recheck_delay_in;
   logic [5:0]  readout_step_ff, readout_step_in;
   logic [7:0]  release_mask_ff, release_mask_in;

   logic [7:0]  switch_history_ff, switch_history_in;
   logic [7:0]  press_ticks_ff, press_ticks_in;
   logic [15:0] turbo_ticks_ff, turbo_ticks_in;
   logic [7:0]  check_wait_ff, check_wait_in;
   logic [7:0]  lit_ticks_ff, lit_ticks_in;
   logic [2:0]  low_strikes_ff, low_strikes_in;
   logic [2:0]  mode_ff, mode_in;
   logic        readout_armed_ff, readout_armed_in;

   logic        ready_ff, ready_in;
   logic [7:0]  sample_ff, sample_in;
   logic        start_ff, start_in;
   logic        do_press_ff, do_press_in;
   logic        do_blink_ff, do_blink_in;

   logic [7:0]  rem_ff, rem_in;
   logic [7:0]  quo_ff, quo_in;
   logic [6:0]  divisor_ff, divisor_in;
   logic [2:0]  count_ff, count_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_mode_number_ff, rsp_mode_number_in;
   logic [7:0]  rsp_drive_level_ff, rsp_drive_level_in;
   logic        rsp_start_sample_ff, rsp_start_sample_in;
   logic [7:0]  rsp_blink_count_ff, rsp_blink_count_in;

   logic [6:0]  long_len;
   logic [7:0]  long_len_x2;
   logic [5:0]  step_size;
   logic [7:0]  press_next;

   assign long_len    = (long_press_ticks_ff < 7'd2) ? 7'd2 : long_press_ticks_ff;
   assign long_len_x2 = {long_len, 1'b0};
   assign step_size   = (readout_step_ff == 6'd0) ? 6'd1 : readout_step_ff;
   assign press_next  = (press_ticks_ff == 8'hFF) ? press_ticks_ff
                                                  : press_ticks_ff + 8'd1;

   always_comb begin
      logic [2:0]  mode_a;
      logic [2:0]  strikes_a;
      logic [7:0]  limit;
      logic [7:0]  trial;
      logic [15:0] turbo_next;

      state_in              = state_ff;
      reverse_order_in      = reverse_order_ff;
      long_press_ticks_in   = long_press_ticks_ff;
      turbo_limit_in        = turbo_limit_ff;
      low_threshold_in      = low_threshold_ff;
      critical_threshold_in = critical_threshold_ff;
      recheck_delay_in      = recheck_delay_ff;
      readout_step_in       = readout_step_ff;
      release_mask_in       = release_mask_ff;
      switch_history_in     = switch_history_ff;
      press_ticks_in        = press_ticks_ff;
      turbo_ticks_in        = turbo_ticks_ff;
      check_wait_in         = check_wait_ff;
      lit_ticks_in          = lit_ticks_ff;
      low_strikes_in        = low_strikes_ff;
      mode_in               = mode_ff;
      readout_armed_in      = readout_armed_ff;
      ready_in              = ready_ff;
      sample_in             = sample_ff;
      start_in              = start_ff;
      do_press_in           = do_press_ff;
      do_blink_in           = do_blink_ff;
      rem_in                = rem_ff;
      quo_in                = quo_ff;
      divisor_in            = divisor_ff;
      count_in              = count_ff;
      rsp_valid_in          = rsp_valid_ff & rsp_stall;
      rsp_mode_number_in    = rsp_mode_number_ff;
      rsp_drive_level_in    = rsp_drive_level_ff;
      rsp_start_sample_in   = rsp_start_sample_ff;
      rsp_blink_count_in    = rsp_blink_count_ff;
      mode_a                = mode_ff;
      strikes_a             = low_strikes_ff;
      limit                 = low_threshold_ff;
      trial                 = {rem_ff[6:0], quo_ff[7]};
      turbo_next            = turbo_ticks_ff + 16'd1;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_REVERSE_ORDER:      reverse_order_in      = csr_write_data[0];
            CSR_LONG_PRESS_TICKS:   long_press_ticks_in   = csr_write_data[6:0];
            CSR_TURBO_LIMIT:        turbo_limit_in        = csr_write_data[15:0];
            CSR_LOW_THRESHOLD:      low_threshold_in      = csr_write_data[7:0];
            CSR_CRITICAL_THRESHOLD: critical_threshold_in = csr_write_data[7:0];
            CSR_RECHECK_DELAY:      recheck_delay_in      = csr_write_data[7:0];
            CSR_READOUT_STEP:       readout_step_in       = csr_write_data[5:0];
            CSR_RELEASE_MASK:       release_mask_in       = csr_write_data[7:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ready_in          = req_sample_ready;
               sample_in         = req_battery_sample;
               switch_history_in = {switch_history_ff[6:0], req_switch_down};
               if (mode_ff == 3'd0) begin
                  lit_ticks_in = 8'd0;
               end else if (lit_ticks_ff != 8'hFF) begin
                  lit_ticks_in = lit_ticks_ff + 8'd1;
               end
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            start_in    = 1'b0;
            do_press_in = 1'b0;
            do_blink_in = 1'b0;
            rem_in      = 8'd0;
            count_in    = 3'd0;
            if ((switch_history_ff & release_mask_ff) != 8'd0) begin
               press_ticks_in = press_next;
               turbo_ticks_in = 16'd0;
               check_wait_in  = recheck_delay_ff;
               quo_in         = press_next;
               divisor_in     = long_len;
               do_press_in    = 1'b1;
               state_in       = ST_DIVIDE;
            end else begin
               press_ticks_in = 8'd0;
               state_in       = ST_FINISH;
               if (press_ticks_ff != 8'd0 && press_ticks_ff < {1'b0, long_len}) begin
                  mode_a = reverse_order_ff ? mode_up(mode_ff) : mode_down(mode_ff);
                  if (lit_ticks_ff < long_len_x2) begin
                     lit_ticks_in = 8'd1;
                     if (mode_a == 3'd0) begin
                        readout_armed_in = 1'b1;
                     end
                  end
               end else begin
                  if (level_of(mode_ff) == FULL_LEVEL) begin
                     turbo_ticks_in = turbo_next;
                     if (turbo_next > turbo_limit_ff) begin
                        mode_a = mode_down(mode_ff);
                     end
                  end
                  if (check_wait_ff != 8'd0) begin
                     check_wait_in = check_wait_ff - 8'd1;
                  end else begin
                     if (ready_ff) begin
                        limit = (mode_a == 3'd1) ? critical_threshold_ff : low_threshold_ff;
                        if (sample_ff < limit) begin
                           if (low_strikes_ff != 3'd7) begin
                              strikes_a = low_strikes_ff + 3'd1;
                           end
                        end else begin
                           strikes_a = 3'd0;
                        end
                        if (readout_armed_ff) begin
                           readout_armed_in = 1'b0;
                           if (sample_ff >= low_threshold_ff) begin
                              quo_in      = sample_ff - low_threshold_ff;
                              divisor_in  = {1'b0, step_size};
                              do_blink_in = 1'b1;
                              state_in    = ST_DIVIDE;
                           end
                        end
                     end
                     if (strikes_a >= STRIKE_LIMIT) begin
                        mode_a        = mode_down(mode_a);
                        strikes_a     = 3'd0;
                        check_wait_in = recheck_delay_ff;
                     end
                     low_strikes_in = strikes_a;
                     start_in       = 1'b1;
                  end
               end
               mode_in = mode_a;
            end
         end
         ST_DIVIDE: begin
            if (trial >= {1'b0, divisor_ff}) begin
               rem_in = trial - {1'b0, divisor_ff};
               quo_in = {quo_ff[6:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[6:0], 1'b0};
            end
            count_in = count_ff + 3'd1;
            if (count_ff == 3'd7) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               if (do_press_ff && rem_ff == {1'b0, long_len} - 8'd1) begin
                  mode_a = reverse_order_ff ? mode_down(mode_ff) : mode_up(mode_ff);
               end
               if (do_press_ff && press_ticks_ff == long_len_x2) begin
                  press_ticks_in = {1'b0, long_len};
               end
               mode_in             = mode_a;
               rsp_valid_in        = 1'b1;
               rsp_mode_number_in  = mode_a;
               rsp_drive_level_in  = level_of(mode_a);
               rsp_start_sample_in = start_ff;
               rsp_blink_count_in  = do_blink_ff ? quo_ff : 8'd0;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff              <= ST_IDLE;
         reverse_order_ff      <= REVERSE_ORDER_RESET;
         long_press_ticks_ff   <= LONG_PRESS_TICKS_RESET;
         turbo_limit_ff        <= TURBO_LIMIT_RESET;
         low_threshold_ff      <= LOW_THRESHOLD_RESET;
         critical_threshold_ff <= CRITICAL_THRESHOLD_RESET;
         recheck_delay_ff      <= RECHECK_DELAY_RESET;
         readout_step_ff       <= READOUT_STEP_RESET;
         release_mask_ff       <= RELEASE_MASK_RESET;
         switch_history_ff     <= 8'd0;
         press_ticks_ff        <= 8'd0;
         turbo_ticks_ff        <= 16'd0;
         check_wait_ff         <= RECHECK_DELAY_RESET;
         lit_ticks_ff          <= 8'd0;
         low_strikes_ff        <= 3'd0;
         mode_ff               <= 3'd0;
         readout_armed_ff      <= 1'b0;
         start_ff              <= 1'b0;
         do_press_ff           <= 1'b0;
         do_blink_ff           <= 1'b0;
         count_ff              <= 3'd0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         state_ff              <= state_in;
         reverse_order_ff      <= reverse_order_in;
         long_press_ticks_ff   <= long_press_ticks_in;
         turbo_limit_ff        <= turbo_limit_in;
         low_threshold_ff      <= low_threshold_in;
         critical_threshold_ff <= critical_threshold_in;
         recheck_delay_ff      <= recheck_delay_in;
         readout_step_ff       <= readout_step_in;
         release_mask_ff       <= release_mask_in;
         switch_history_ff     <= switch_history_in;
         press_ticks_ff        <= press_ticks_in;
         turbo_ticks_ff        <= turbo_ticks_in;
         check_wait_ff         <= check_wait_in;
         lit_ticks_ff          <= lit_ticks_in;
         low_strikes_ff        <= low_strikes_in;
         mode_ff               <= mode_in;
         readout_armed_ff      <= readout_armed_in;
         start_ff              <= start_in;
         do_press_ff           <= do_press_in;
         do_blink_ff           <= do_blink_in;
         count_ff              <= count_in;
         rsp_valid_ff          <= rsp_valid_in;
      end
      ready_ff            <= ready_in;
      sample_ff           <= sample_in;
      rem_ff              <= rem_in;
      quo_ff              <= quo_in;
      divisor_ff          <= divisor_in;
      rsp_mode_number_ff  <= rsp_mode_number_in;
      rsp_drive_level_ff  <= rsp_drive_level_in;
      rsp_start_sample_ff <= rsp_start_sample_in;
      rsp_blink_count_ff  <= rsp_blink_count_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mode_number  = rsp_mode_number_ff;
   assign rsp_drive_level  = rsp_drive_level_ff;
   assign rsp_start_sample = rsp_start_sample_ff;
   assign rsp_blink_count  = rsp_blink_count_ff;

endmodule
`default_nettype wire

@@ design/ssmc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Single-switch mode controller checker
// Port-level properties of the mode controller, bound to the top level.
// ----------------------------------------------------------------------------
module ssmc_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [2:0]                   rsp_mode_number,
   input wire logic [7:0]                   rsp_drive_level,
   input wire logic                         rsp_start_sample,
   input wire logic [7:0]                   rsp_blink_count
);
   import ssmc_pkg::*;

   // A stalled response word holds.
   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mode_number)
         && $stable(rsp_drive_level) && $stable(rsp_start_sample)
         && $stable(rsp_blink_count))
      else $error("response word changed under stall");

   // The drive level always matches the reported mode.
   level_match_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drive_level == level_of(rsp_mode_number)
         && rsp_mode_number < MODE_WIDTH'(MODE_COUNT))
      else $error("drive level does not match mode");

   // A readout only happens on a tick that ran the battery check.
   blink_check_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_blink_count != 8'd0 |-> rsp_start_sample)
      else $error("blink count without battery check");

   // One word is processed at a time.
   busy_after_accept_a: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous word in progress");

endmodule

bind single_switch_mode_controller ssmc_checker u_ssmc_checker (.*);
`default_nettype wire
